FILE: rtl/lscc_pkg.sv
package lscc_pkg;

  // Fixed field widths
  localparam int FIELD_W    = 12;
  localparam int FUNC_W     = 2;
  localparam int PHASE_W    = 3;
  localparam int STATUS_W   = 3;
  localparam int NUM_CH     = 3;
  localparam int CFG_IDX_W  = 2;

  // Parameter defaults
  localparam int AVG_LEN_DEF  = 64;
  localparam int ADC_BITS_DEF = 12;

  // Channel order
  localparam int CH_LEFT   = 0;
  localparam int CH_MIDDLE = 1;
  localparam int CH_RIGHT  = 2;

  // Event kinds
  localparam logic [FUNC_W-1:0] FN_SAMPLE = 2'd0;
  localparam logic [FUNC_W-1:0] FN_BUTTON = 2'd1;
  localparam logic [FUNC_W-1:0] FN_START  = 2'd2;

  // Calibration phases
  localparam logic [PHASE_W-1:0] PH_IDLE         = 3'd0;
  localparam logic [PHASE_W-1:0] PH_WAIT_WHITE   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SAMPLE_WHITE = 3'd2;
  localparam logic [PHASE_W-1:0] PH_WAIT_BLACK   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_SAMPLE_BLACK = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_TRIP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_TRIP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_TRIP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_PRES = 2'd3;

  localparam logic [FIELD_W-1:0] TRIP_RESET = 12'd2048;

  // One event, samples already masked
  typedef struct packed {
    logic [FUNC_W-1:0]              func;
    logic [NUM_CH-1:0][FIELD_W-1:0] smp;
  } cal_item_t;

  // Calibration state seen by the classifier and result path
  typedef struct packed {
    logic [PHASE_W-1:0]             phase_next;
    logic                           done;
    logic                           valid;
    logic                           valid_next;
    logic [NUM_CH-1:0][FIELD_W-1:0] trips;
    logic [NUM_CH-1:0][FIELD_W-1:0] trips_next;
  } cal_stat_t;

endpackage

FILE: rtl/line_sensor_calibrate_classify_core.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser: func; tdata: samples
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: status, phase, done, trips
// cfg       in   cfg_we (no wait)               cfg_index, cfg_data
//
// One item per cycle sustained while m_axis is ready; an item's result reaches
// m_axis through the input register, then the result register. The calibration
// state and the reciprocal-multiply averaging sit between those two registers.
// rst is synchronous: phase idle, stored trips 2048, middle sensor present.
// A stall on m_axis holds the result register; s_axis keeps accepting until
// the input register is also full.
module line_sensor_calibrate_classify_core #(
  parameter int AVG_LEN  = lscc_pkg::AVG_LEN_DEF,
  parameter int ADC_BITS = lscc_pkg::ADC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // stream in
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [39:0]                       s_axis_tdata,  // left, middle, right
  input  logic [lscc_pkg::FUNC_W-1:0]       s_axis_tuser,  // func
  // stream out
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // line_status, cal_phase, cal_done, left_trip_now, middle_trip_now, right_trip_now
  output logic [47:0]                       m_axis_tdata,
  // configuration
  input  logic                              cfg_we,
  input  logic [lscc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lscc_pkg::FIELD_W-1:0]      cfg_data
);

  localparam int FW  = lscc_pkg::FIELD_W;
  localparam int NCH = lscc_pkg::NUM_CH;
  localparam logic [FW-1:0] ADC_MASK =
    (ADC_BITS >= FW) ? {FW{1'b1}} : FW'((64'd1 << ADC_BITS) - 64'd1);

  // configuration registers
  logic [NCH-1:0][FW-1:0] stored_trips;
  logic                   middle_present;

  // input register
  logic                          in_valid;
  logic [lscc_pkg::FUNC_W-1:0]   in_func;
  logic [NCH-1:0][FW-1:0]        in_smp;

  // result register
  logic                           out_valid;
  logic [lscc_pkg::STATUS_W-1:0]  out_status;
  logic [lscc_pkg::PHASE_W-1:0]   out_phase;
  logic                           out_done;
  logic [NCH-1:0][FW-1:0]         out_trips;

  logic                           advance;
  lscc_pkg::cal_item_t            item;
  lscc_pkg::cal_stat_t            stat;
  logic [NCH-1:0][FW-1:0]         trip_before, trip_after;
  logic [lscc_pkg::STATUS_W-1:0]  status;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_trips   <= {NCH{lscc_pkg::TRIP_RESET}};
      middle_present <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        lscc_pkg::CFG_LEFT_TRIP:   stored_trips[lscc_pkg::CH_LEFT]   <= cfg_data;
        lscc_pkg::CFG_MIDDLE_TRIP: stored_trips[lscc_pkg::CH_MIDDLE] <= cfg_data;
        lscc_pkg::CFG_RIGHT_TRIP:  stored_trips[lscc_pkg::CH_RIGHT]  <= cfg_data;
        lscc_pkg::CFG_MIDDLE_PRES: middle_present <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline handshake
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func <= s_axis_tuser;
      in_smp  <= s_axis_tdata[NCH*FW-1:0];
    end
  end

  // Masked samples; an absent middle sensor reads as zero
  assign item.func                  = in_func;
  assign item.smp[lscc_pkg::CH_LEFT]   = in_smp[lscc_pkg::CH_LEFT] & ADC_MASK;
  assign item.smp[lscc_pkg::CH_MIDDLE] =
    middle_present ? (in_smp[lscc_pkg::CH_MIDDLE] & ADC_MASK) : '0;
  assign item.smp[lscc_pkg::CH_RIGHT]  = in_smp[lscc_pkg::CH_RIGHT] & ADC_MASK;

  lscc_cal #(
    .AVG_LEN(AVG_LEN)
  ) u_cal (
    .clk (clk),
    .rst (rst),
    .step(advance),
    .item(item),
    .stat(stat)
  );

  // Trips in force before and after this item
  assign trip_before = stat.valid      ? stat.trips      : stored_trips;
  assign trip_after  = stat.valid_next ? stat.trips_next : stored_trips;

  // Classify against the trips before the item
  always_comb begin
    status = '0;
    if (item.func == lscc_pkg::FN_SAMPLE) begin
      status[2] = item.smp[lscc_pkg::CH_LEFT]   > trip_before[lscc_pkg::CH_LEFT];
      status[1] = item.smp[lscc_pkg::CH_MIDDLE] > trip_before[lscc_pkg::CH_MIDDLE];
      status[0] = item.smp[lscc_pkg::CH_RIGHT]  > trip_before[lscc_pkg::CH_RIGHT];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status <= status;
      out_phase  <= stat.phase_next;
      out_done   <= stat.done;
      out_trips  <= trip_after;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_trips, out_done, out_phase, out_status};

  // Checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_done |-> out_phase == lscc_pkg::PH_IDLE)
    else $error("calibration done without returning to idle");

  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    advance && stat.done |=> stat.valid)
    else $error("calibrated trips not in force after done");

  a_status_only_sample: assert property (@(posedge clk) disable iff (rst)
    advance && item.func != lscc_pkg::FN_SAMPLE |=> out_status == '0)
    else $error("line status set on a non-sample item");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_axis_tready)
    else $error("input stalled while result register empty");

endmodule

FILE: rtl/lscc_avg_div.sv
// Channel sum divided by the averaging length: multiply by a rounded-up
// reciprocal. With K = SUM_W + clog2(N) the floor is exact for every sum
// below 2^SUM_W.
module lscc_avg_div #(
  parameter int AVG_LEN = lscc_pkg::AVG_LEN_DEF,
  parameter int SUM_W   = lscc_pkg::FIELD_W + $clog2(lscc_pkg::AVG_LEN_DEF)
) (
  input  logic [SUM_W-1:0]             sum,
  output logic [lscc_pkg::FIELD_W-1:0] avg
);

  localparam int K   = SUM_W + $clog2(AVG_LEN);
  localparam int M_W = SUM_W + 2;
  localparam int P_W = SUM_W + M_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << K) + 64'(AVG_LEN) - 64'd1) / 64'(AVG_LEN);
  localparam logic [M_W-1:0] RECIP = RECIP_FULL[M_W-1:0];

  logic [P_W-1:0] prod;

  assign prod = P_W'(sum) * P_W'(RECIP);
  assign avg  = prod[K +: lscc_pkg::FIELD_W];

endmodule

FILE: rtl/lscc_cal.sv
// Two-point calibration: phase control, per-channel accumulation,
// averages and calibrated trips.
module lscc_cal #(
  parameter int AVG_LEN = lscc_pkg::AVG_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  lscc_pkg::cal_item_t  item,
  output lscc_pkg::cal_stat_t  stat
);

  localparam int CNT_W = $clog2(AVG_LEN + 1);
  localparam int SUM_W = lscc_pkg::FIELD_W + $clog2(AVG_LEN);
  localparam int FW    = lscc_pkg::FIELD_W;
  localparam int NCH   = lscc_pkg::NUM_CH;

  logic [lscc_pkg::PHASE_W-1:0] phase, phase_next;
  logic [CNT_W-1:0]             count, count_next, count_inc;
  logic [NCH-1:0][SUM_W-1:0]    sums, sums_next, sum_add;
  logic [NCH-1:0][FW-1:0]       white, white_next;
  logic [NCH-1:0][FW-1:0]       trips, trips_next;
  logic [NCH-1:0][FW-1:0]       avg, mid_trip;
  logic                         valid, valid_next;
  logic                         done;
  logic                         sampling, full;

  // Accumulate and divide, one lane per channel
  for (genvar i = 0; i < NCH; i++) begin : g_lane
    assign sum_add[i] = sums[i] + SUM_W'(item.smp[i]);

    lscc_avg_div #(
      .AVG_LEN(AVG_LEN),
      .SUM_W  (SUM_W)
    ) u_div (
      .sum(sum_add[i]),
      .avg(avg[i])
    );

    assign mid_trip[i] = FW'(((FW + 1)'(white[i]) + (FW + 1)'(avg[i])) >> 1);
  end

  assign count_inc = count + 1'b1;
  assign full      = (count_inc >= CNT_W'(AVG_LEN));
  assign sampling  = (phase == lscc_pkg::PH_SAMPLE_WHITE) ||
                     (phase == lscc_pkg::PH_SAMPLE_BLACK);

  // Next-state logic
  always_comb begin
    phase_next = phase;
    count_next = count;
    sums_next  = sums;
    white_next = white;
    trips_next = trips;
    valid_next = valid;
    done       = 1'b0;
    case (item.func)
      lscc_pkg::FN_SAMPLE: begin
        if (sampling) begin
          if (full) begin
            count_next = '0;
            sums_next  = '0;
            if (phase == lscc_pkg::PH_SAMPLE_WHITE) begin
              white_next = avg;
              phase_next = lscc_pkg::PH_WAIT_BLACK;
            end else begin
              trips_next = mid_trip;
              valid_next = 1'b1;
              phase_next = lscc_pkg::PH_IDLE;
              done       = 1'b1;
            end
          end else begin
            count_next = count_inc;
            sums_next  = sum_add;
          end
        end
      end
      lscc_pkg::FN_BUTTON: begin
        if (phase == lscc_pkg::PH_WAIT_WHITE) begin
          count_next = '0;
          sums_next  = '0;
          phase_next = lscc_pkg::PH_SAMPLE_WHITE;
        end else if (phase == lscc_pkg::PH_WAIT_BLACK) begin
          count_next = '0;
          sums_next  = '0;
          phase_next = lscc_pkg::PH_SAMPLE_BLACK;
        end
      end
      lscc_pkg::FN_START: begin
        count_next = '0;
        sums_next  = '0;
        phase_next = lscc_pkg::PH_WAIT_WHITE;
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= lscc_pkg::PH_IDLE;
      count <= '0;
      valid <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      count <= count_next;
      valid <= valid_next;
    end
  end

  // Sums, averages and trips; sums are cleared before any sampling phase
  always_ff @(posedge clk) begin
    if (step) begin
      sums  <= sums_next;
      white <= white_next;
      trips <= trips_next;
    end
  end

  assign stat.phase_next = phase_next;
  assign stat.done       = done;
  assign stat.valid      = valid;
  assign stat.valid_next = valid_next;
  assign stat.trips      = trips;
  assign stat.trips_next = trips_next;

endmodule

FILE: verif/line_sensor_calibrate_classify_checker.sv
// Watches the item and config ports of the line sensor core, keeps its own
// copy of the calibration state, predicts one result per accepted item and
// compares every field of each result with the oldest prediction.
module line_sensor_calibrate_classify_checker #(
  parameter int AVG_LEN = lscc_pkg::AVG_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [39:0]                    s_axis_tdata,   // left, middle, right
  input  logic [lscc_pkg::FUNC_W-1:0]    s_axis_tuser,   // func
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // line_status, cal_phase, cal_done, left_trip_now, middle_trip_now, right_trip_now
  input  logic [47:0]                    m_axis_tdata,
  input  logic                           cfg_we,
  input  logic [lscc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lscc_pkg::FIELD_W-1:0]   cfg_data,
  output int                             n_open,
  output int                             n_fail,
  output int                             n_checked,
  output int                             n_cal
);

  localparam int MAX_PRINTS = 40;

  // Result layout, lowest field last
  typedef struct packed {
    logic [4:0]                    pad;
    logic [lscc_pkg::FIELD_W-1:0]  right_trip;
    logic [lscc_pkg::FIELD_W-1:0]  middle_trip;
    logic [lscc_pkg::FIELD_W-1:0]  left_trip;
    logic                          done;
    logic [lscc_pkg::PHASE_W-1:0]  phase;
    logic [lscc_pkg::STATUS_W-1:0] status;
  } line_result_t;

  // Shadow of the block's state and registers
  logic [lscc_pkg::PHASE_W-1:0] cal_ph;
  int unsigned                  taken;
  logic [18:0]                  acc          [lscc_pkg::NUM_CH];
  logic [lscc_pkg::FIELD_W-1:0] white_avg    [lscc_pkg::NUM_CH];
  logic [lscc_pkg::FIELD_W-1:0] learned_trip [lscc_pkg::NUM_CH];
  logic [lscc_pkg::FIELD_W-1:0] stored_trip  [lscc_pkg::NUM_CH];
  logic                         learned_ok;
  logic                         mid_fitted;

  line_result_t pending_results[$];

  function automatic logic [lscc_pkg::FIELD_W-1:0] trip_in_force(input int ch);
    return learned_ok ? learned_trip[ch] : stored_trip[ch];
  endfunction

  task automatic clear_acc();
    taken = 0;
    for (int ch = 0; ch < lscc_pkg::NUM_CH; ch++) acc[ch] = '0;
  endtask

  task automatic report(input string what, input longint unsigned got_v,
                        input longint unsigned want_v);
    if (n_fail < MAX_PRINTS)
      $display("mismatch at result %0d, %s: got %0d, expected %0d",
               n_checked, what, got_v, want_v);
    n_fail++;
  endtask

  // Work out the result of one accepted item and advance the shadow state
  task automatic classify_event(input logic [lscc_pkg::FUNC_W-1:0] fn,
                                input logic [39:0] data);
    logic [lscc_pkg::FIELD_W-1:0] s [lscc_pkg::NUM_CH];
    logic [lscc_pkg::FIELD_W:0]   mid;
    line_result_t                 r;
    r = '0;
    s[lscc_pkg::CH_LEFT]   = data[11:0];
    s[lscc_pkg::CH_MIDDLE] = mid_fitted ? data[23:12] : '0;
    s[lscc_pkg::CH_RIGHT]  = data[35:24];
    case (fn)
      lscc_pkg::FN_SAMPLE: begin
        // classified against the trips in force before this item
        for (int ch = 0; ch < lscc_pkg::NUM_CH; ch++)
          if (s[ch] > trip_in_force(ch)) r.status[lscc_pkg::NUM_CH-1-ch] = 1'b1;
        if (cal_ph == lscc_pkg::PH_SAMPLE_WHITE ||
            cal_ph == lscc_pkg::PH_SAMPLE_BLACK) begin
          for (int ch = 0; ch < lscc_pkg::NUM_CH; ch++) acc[ch] = acc[ch] + 19'(s[ch]);
          taken++;
          if (taken >= AVG_LEN) begin
            if (cal_ph == lscc_pkg::PH_SAMPLE_WHITE) begin
              for (int ch = 0; ch < lscc_pkg::NUM_CH; ch++)
                white_avg[ch] = lscc_pkg::FIELD_W'(acc[ch] / AVG_LEN);
              cal_ph = lscc_pkg::PH_WAIT_BLACK;
            end else begin
              // floored midpoint of white and black averages
              for (int ch = 0; ch < lscc_pkg::NUM_CH; ch++) begin
                mid = (lscc_pkg::FIELD_W+1)'(white_avg[ch]) +
                      (lscc_pkg::FIELD_W+1)'(acc[ch] / AVG_LEN);
                learned_trip[ch] = mid[lscc_pkg::FIELD_W:1];
              end
              learned_ok = 1'b1;
              cal_ph     = lscc_pkg::PH_IDLE;
              r.done     = 1'b1;
              n_cal++;
            end
            clear_acc();
          end
        end
      end
      lscc_pkg::FN_BUTTON: begin
        if (cal_ph == lscc_pkg::PH_WAIT_WHITE) begin
          clear_acc();
          cal_ph = lscc_pkg::PH_SAMPLE_WHITE;
        end else if (cal_ph == lscc_pkg::PH_WAIT_BLACK) begin
          clear_acc();
          cal_ph = lscc_pkg::PH_SAMPLE_BLACK;
        end
      end
      lscc_pkg::FN_START: begin
        clear_acc();
        cal_ph = lscc_pkg::PH_WAIT_WHITE;
      end
      default: ;
    endcase
    r.phase       = cal_ph;
    r.left_trip   = trip_in_force(lscc_pkg::CH_LEFT);
    r.middle_trip = trip_in_force(lscc_pkg::CH_MIDDLE);
    r.right_trip  = trip_in_force(lscc_pkg::CH_RIGHT);
    pending_results.push_back(r);
  endtask

  task automatic check_result(input logic [47:0] raw);
    line_result_t got, want;
    got = line_result_t'(raw);
    n_checked++;
    if (pending_results.size() == 0) begin
      report("result with no item pending", raw, 0);
      return;
    end
    want = pending_results.pop_front();
    if (got.status != want.status) report("line_status", got.status, want.status);
    if (got.phase != want.phase) report("cal_phase", got.phase, want.phase);
    if (got.done != want.done) report("cal_done", got.done, want.done);
    if (got.left_trip != want.left_trip)
      report("left_trip_now", got.left_trip, want.left_trip);
    if (got.middle_trip != want.middle_trip)
      report("middle_trip_now", got.middle_trip, want.middle_trip);
    if (got.right_trip != want.right_trip)
      report("right_trip_now", got.right_trip, want.right_trip);
    if (got.pad != want.pad) report("tdata padding", got.pad, want.pad);
  endtask

  // Config first, then results out, then items in
  always @(posedge clk) begin
    if (rst) begin
      cal_ph     = lscc_pkg::PH_IDLE;
      clear_acc();
      for (int ch = 0; ch < lscc_pkg::NUM_CH; ch++) begin
        white_avg[ch]    = '0;
        learned_trip[ch] = '0;
        stored_trip[ch]  = lscc_pkg::TRIP_RESET;
      end
      learned_ok = 1'b0;
      mid_fitted = 1'b1;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lscc_pkg::CFG_LEFT_TRIP:   stored_trip[lscc_pkg::CH_LEFT]   = cfg_data;
          lscc_pkg::CFG_MIDDLE_TRIP: stored_trip[lscc_pkg::CH_MIDDLE] = cfg_data;
          lscc_pkg::CFG_RIGHT_TRIP:  stored_trip[lscc_pkg::CH_RIGHT]  = cfg_data;
          lscc_pkg::CFG_MIDDLE_PRES: mid_fitted                       = cfg_data[0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) classify_event(s_axis_tuser, s_axis_tdata);
    end
    n_open <= pending_results.size();
  end

endmodule

FILE: verif/tb_line_sensor_calibrate_classify_core.sv
module tb_line_sensor_calibrate_classify_core;

  localparam logic [lscc_pkg::FUNC_W-1:0]  FN_UNUSED    = 2'd3;
  localparam logic [lscc_pkg::FIELD_W-1:0] ADC_MAX      = '1;
  localparam int                           EVENT_TARGET = 800;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [39:0]                    s_axis_tdata = '0;                   // left, middle, right
  logic [lscc_pkg::FUNC_W-1:0]    s_axis_tuser = lscc_pkg::FN_SAMPLE;  // func
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // line_status, cal_phase, cal_done, left_trip_now, middle_trip_now, right_trip_now
  logic [47:0]                    m_axis_tdata;
  logic                           cfg_we = 1'b0;
  logic [lscc_pkg::CFG_IDX_W-1:0] cfg_index = lscc_pkg::CFG_LEFT_TRIP;
  logic [lscc_pkg::FIELD_W-1:0]   cfg_data = '0;

  int          n_open, n_fail, n_checked, n_cal;
  int          burst_left = 0;
  int          n_events = 0;
  int unsigned rx_cyc = 0;
  int          rx_mode = 0;

  line_sensor_calibrate_classify_core dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  line_sensor_calibrate_classify_checker chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .n_open(n_open), .n_fail(n_fail), .n_checked(n_checked), .n_cal(n_cal)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: switches among random stall patterns
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc % 128 == 0) rx_mode <= int'($urandom_range(0, 3));
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= (rx_cyc % 8 != 0);
      default: m_axis_tready <= ((rx_cyc / 16) % 2 == 0);
    endcase
  end

  // Reading biased toward zero, full scale and the reset trip
  function automatic logic [lscc_pkg::FIELD_W-1:0] pick_adc();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ADC_MAX;
      2:       return lscc_pkg::FIELD_W'(int'(lscc_pkg::TRIP_RESET) +
                                         int'($urandom_range(0, 2)) - 1);
      default: return lscc_pkg::FIELD_W'($urandom);
    endcase
  endfunction

  function automatic logic [lscc_pkg::FIELD_W-1:0] near(
      input logic [lscc_pkg::FIELD_W-1:0] level, input int spread);
    int v;
    v = int'(level) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > int'(ADC_MAX)) v = int'(ADC_MAX);
    return lscc_pkg::FIELD_W'(v);
  endfunction

  // One item; the sender runs in bursts with random gaps in between
  task automatic send(input logic [lscc_pkg::FUNC_W-1:0] fn,
                      input logic [lscc_pkg::FIELD_W-1:0] l, m, r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {4'b0, r, m, l};
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    if (fn != FN_UNUSED) n_events++;
  endtask

  // Stop sending and wait until every result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (n_open != 0);
    burst_left = 0;
  endtask

  task automatic set_regs(input logic [lscc_pkg::FIELD_W-1:0] lt, mt, rt,
                          input logic mp);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= lscc_pkg::CFG_LEFT_TRIP;
    cfg_data  <= lt;
    @(posedge clk);
    cfg_index <= lscc_pkg::CFG_MIDDLE_TRIP;
    cfg_data  <= mt;
    @(posedge clk);
    cfg_index <= lscc_pkg::CFG_RIGHT_TRIP;
    cfg_data  <= rt;
    @(posedge clk);
    cfg_index <= lscc_pkg::CFG_MIDDLE_PRES;
    cfg_data  <= lscc_pkg::FIELD_W'(mp);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Stray buttons or unused func codes sprinkled into a sequence
  task automatic noise(input int pct);
    if ($urandom_range(0, 99) < pct)
      send($urandom_range(0, 1) ? lscc_pkg::FN_BUTTON : FN_UNUSED,
           lscc_pkg::FIELD_W'($urandom), lscc_pkg::FIELD_W'($urandom),
           lscc_pkg::FIELD_W'($urandom));
  endtask

  task automatic random_items(input int n);
    logic [lscc_pkg::FUNC_W-1:0] fn;
    repeat (n) begin
      case ($urandom_range(0, 19))
        0, 1, 2:    fn = lscc_pkg::FN_BUTTON;
        3, 4:       fn = lscc_pkg::FN_START;
        5, 6, 7:    fn = FN_UNUSED;
        default:    fn = lscc_pkg::FN_SAMPLE;
      endcase
      if ($urandom_range(0, 1))
        send(fn, pick_adc(), pick_adc(), pick_adc());
      else
        send(fn, lscc_pkg::FIELD_W'($urandom), lscc_pkg::FIELD_W'($urandom),
             lscc_pkg::FIELD_W'($urandom));
    end
  endtask

  // Full two-point calibration with random levels, spread and noise;
  // sometimes restarted partway through the white pass
  task automatic calibrate(input int pct);
    logic [lscc_pkg::FIELD_W-1:0] white [lscc_pkg::NUM_CH];
    logic [lscc_pkg::FIELD_W-1:0] black [lscc_pkg::NUM_CH];
    int spread, n, abort_at;
    for (int ch = 0; ch < lscc_pkg::NUM_CH; ch++) begin
      white[ch] = pick_adc();
      black[ch] = pick_adc();
    end
    spread   = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 600);
    abort_at = ($urandom_range(0, 4) == 0) ?
               $urandom_range(0, lscc_pkg::AVG_LEN_DEF - 1) : -1;
    send(lscc_pkg::FN_START, pick_adc(), pick_adc(), pick_adc());
    repeat ($urandom_range(0, 3))
      send(lscc_pkg::FN_SAMPLE, pick_adc(), pick_adc(), pick_adc());
    send(lscc_pkg::FN_BUTTON, pick_adc(), pick_adc(), pick_adc());
    n = 0;
    while (n < lscc_pkg::AVG_LEN_DEF) begin
      if (n == abort_at) begin
        abort_at = -1;
        send(lscc_pkg::FN_START, pick_adc(), pick_adc(), pick_adc());
        send(lscc_pkg::FN_BUTTON, pick_adc(), pick_adc(), pick_adc());
        n = 0;
      end
      noise(pct);
      send(lscc_pkg::FN_SAMPLE, near(white[lscc_pkg::CH_LEFT], spread),
           near(white[lscc_pkg::CH_MIDDLE], spread),
           near(white[lscc_pkg::CH_RIGHT], spread));
      n++;
    end
    repeat ($urandom_range(0, 3))
      send(lscc_pkg::FN_SAMPLE, pick_adc(), pick_adc(), pick_adc());
    noise(pct);
    send(lscc_pkg::FN_BUTTON, pick_adc(), pick_adc(), pick_adc());
    repeat (lscc_pkg::AVG_LEN_DEF) begin
      noise(pct);
      send(lscc_pkg::FN_SAMPLE, near(black[lscc_pkg::CH_LEFT], spread),
           near(black[lscc_pkg::CH_MIDDLE], spread),
           near(black[lscc_pkg::CH_RIGHT], spread));
    end
    // classified against the fresh trips
    repeat ($urandom_range(1, 4))
      send(lscc_pkg::FN_SAMPLE, pick_adc(), pick_adc(), pick_adc());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: compare edges at the reset trips
    send(lscc_pkg::FN_SAMPLE, '0, '0, '0);
    send(lscc_pkg::FN_SAMPLE, ADC_MAX, ADC_MAX, ADC_MAX);
    send(lscc_pkg::FN_SAMPLE, lscc_pkg::TRIP_RESET, lscc_pkg::TRIP_RESET,
         lscc_pkg::TRIP_RESET);
    send(lscc_pkg::FN_SAMPLE, lscc_pkg::TRIP_RESET + 12'd1, lscc_pkg::TRIP_RESET,
         lscc_pkg::TRIP_RESET + 12'd1);
    send(lscc_pkg::FN_SAMPLE, lscc_pkg::TRIP_RESET, lscc_pkg::TRIP_RESET + 12'd1,
         lscc_pkg::TRIP_RESET);
    // unused func, button while idle
    send(FN_UNUSED, ADC_MAX, ADC_MAX, ADC_MAX);
    send(lscc_pkg::FN_BUTTON, ADC_MAX, ADC_MAX, ADC_MAX);
    // arm, sample while waiting, start sampling, button while sampling, restarts
    send(lscc_pkg::FN_START, '0, '0, '0);
    send(lscc_pkg::FN_SAMPLE, ADC_MAX, '0, ADC_MAX);
    send(lscc_pkg::FN_BUTTON, '0, '0, '0);
    send(lscc_pkg::FN_BUTTON, '0, '0, '0);
    send(lscc_pkg::FN_SAMPLE, ADC_MAX, ADC_MAX, ADC_MAX);
    send(lscc_pkg::FN_START, '0, '0, '0);
    send(lscc_pkg::FN_START, '0, '0, '0);
    send(FN_UNUSED, '0, '0, '0);
    // stored trips at the extremes, middle sensor absent then fitted
    set_regs('0, ADC_MAX, '0, 1'b0);
    send(lscc_pkg::FN_SAMPLE, 12'd1, ADC_MAX, 12'd1);
    send(lscc_pkg::FN_SAMPLE, '0, ADC_MAX, '0);
    set_regs(ADC_MAX, '0, ADC_MAX, 1'b1);
    send(lscc_pkg::FN_SAMPLE, ADC_MAX, 12'd1, ADC_MAX);
    send(lscc_pkg::FN_SAMPLE, ADC_MAX, '0, ADC_MAX);

    // First calibration with the middle sensor absent
    set_regs(lscc_pkg::TRIP_RESET, lscc_pkg::TRIP_RESET, lscc_pkg::TRIP_RESET, 1'b0);
    calibrate(0);
    set_regs(pick_adc(), pick_adc(), pick_adc(), 1'b1);

    // Random part: mostly clean calibrations, some loose traffic and reconfig
    while (n_events < EVENT_TARGET) begin
      case ($urandom_range(0, 9))
        0:       set_regs(pick_adc(), pick_adc(), pick_adc(), 1'($urandom_range(0, 1)));
        1, 2:    random_items($urandom_range(5, 30));
        default: calibrate($urandom_range(0, 10));
      endcase
    end

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d events, %0d results checked, %0d calibrations completed",
             n_events, n_checked, n_cal);
    if (n_fail == 0)
      $display("line_sensor_calibrate_classify_core regression: pass");
    else
      $display("line_sensor_calibrate_classify_core regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("line_sensor_calibrate_classify_core regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
rtl/lscc_pkg.sv
rtl/lscc_avg_div.sv
rtl/lscc_cal.sv
rtl/line_sensor_calibrate_classify_core.sv
verif/line_sensor_calibrate_classify_checker.sv
verif/tb_line_sensor_calibrate_classify_core.sv
